// ===== rtl/lms_pkg.sv =====
`timescale 1ns / 1ps
package lms_pkg;

  localparam int unsigned DefMaxWidth  = 256;
  localparam int unsigned DefMaxHeight = 256;
  localparam int unsigned CoordW       = 8;
  localparam int unsigned ValW         = 16;
  localparam int unsigned CfgW         = 9;
  localparam logic [ValW-1:0] LightOne = 16'd32768;

  typedef enum logic [1:0] {
    OP_POINT = 2'd0,
    OP_AREA  = 2'd1,
    OP_READ  = 2'd2,
    OP_WRITE = 2'd3
  } op_e;

  typedef enum logic {
    CFG_WIDTH  = 1'b0,
    CFG_HEIGHT = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    logic [1:0]        op;
    logic [CoordW-1:0] center_x;
    logic [CoordW-1:0] center_y;
    logic [CoordW-1:0] radius;
    logic [ValW-1:0]   intensity;
    logic [CoordW-1:0] left;
    logic [CoordW-1:0] top;
    logic [CoordW-1:0] right;
    logic [CoordW-1:0] bottom;
    logic [CoordW-1:0] cell_x;
    logic [CoordW-1:0] cell_y;
    logic [ValW-1:0]   write_value;
  } lms_in_t;

  typedef struct packed {
    logic [ValW-1:0] read_value;
    logic            status;
  } lms_out_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DIV,
    ST_SEG,
    ST_CELL,
    ST_RD,
    ST_WR,
    ST_NEXT,
    ST_RESP
  } state_e;

  // Saturating add: the shared cell update unit.
  function automatic logic [ValW-1:0] sat_add(input logic [ValW-1:0] a,
                                              input logic [ValW-1:0] b);
    logic [ValW:0] s;
    s = {1'b0, a} + {1'b0, b};
    return (s > {1'b0, LightOne}) ? LightOne : s[ValW-1:0];
  endfunction

endpackage

// ===== rtl/light_map_splat_saturating_top.sv =====
`timescale 1ns / 1ps
// Saturating light map, UQ1.15 cells in one single-port-write RAM. After
// reset the block sweeps the whole map to zero, one cell a cycle, and is
// not ready meanwhile. Every lit cell is updated by read, saturating add
// and write in the CELL, RD and WR states; each accepted op also passes
// through decode, setup, result and idle, and a rejected op skips setup.
// A point light of radius r runs a restoring divide per ring plus a setup
// step for each of its four segments. The cell RAM port sets the pace of
// the cell updates.
module light_map_splat_saturating_top
  import lms_pkg::*;
#(
  parameter int unsigned MAX_WIDTH  = DefMaxWidth,
  parameter int unsigned MAX_HEIGHT = DefMaxHeight
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  lms_in_t         in_data_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output lms_out_t        out_data_o,
  input  logic            cfg_valid_i,
  output logic            cfg_ready_o,
  input  logic            cfg_index_i,
  input  logic [CfgW-1:0] cfg_data_i
);

  localparam int unsigned XW    = $clog2(MAX_WIDTH) > 0 ? $clog2(MAX_WIDTH) : 1;
  localparam int unsigned YW    = $clog2(MAX_HEIGHT) > 0 ? $clog2(MAX_HEIGHT) : 1;
  localparam int unsigned Depth = MAX_WIDTH * MAX_HEIGHT;
  localparam int unsigned AW    = $clog2(Depth) > 0 ? $clog2(Depth) : 1;
  // signed coordinate width: room for center plus/minus radius
  localparam int unsigned SW    = 14;
  localparam int unsigned DivW  = 24;

  // configuration registers
  logic [CfgW-1:0] width_q, height_q;
  logic signed [SW-1:0] eff_w, eff_h;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= CfgW'(256);
      height_q <= CfgW'(256);
    end else if (cfg_valid_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_WIDTH:  width_q  <= cfg_data_i;
        CFG_HEIGHT: height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    eff_w = SW'(width_q);
    if (width_q == '0) eff_w = SW'(1);
    if (eff_w > SW'(MAX_WIDTH)) eff_w = SW'(MAX_WIDTH);
    eff_h = SW'(height_q);
    if (height_q == '0) eff_h = SW'(1);
    if (eff_h > SW'(MAX_HEIGHT)) eff_h = SW'(MAX_HEIGHT);
  end

  // sequencer registers
  state_e state_q, state_d;
  lms_in_t req_q;
  lms_out_t res_q;
  logic [AW-1:0] clr_q;
  logic [7:0] d_q;            // ring distance
  logic [2:0] seg_q;          // 0 center,1 top,2 bottom,3 left,4 right
  logic signed [SW-1:0] fix_q, pos_q, hi_q;  // fixed coordinate, running, end
  logic signed [SW-1:0] pos_end_q;
  logic [ValW-1:0] amt_q;
  // restoring divider
  logic [DivW-1:0] num_q, rem_q;
  logic [4:0] dcnt_q;
  logic seg_row_q;            // segment runs along x

  // helpers
  logic signed [SW-1:0] cx, cy, dd;
  assign cx = SW'(req_q.center_x);
  assign cy = SW'(req_q.center_y);
  assign dd = SW'(d_q);

  // segment bounds for the current ring segment
  logic seg_ok;
  logic signed [SW-1:0] s_fix, s_lo, s_hi;
  always_comb begin
    s_fix = '0; s_lo = '0; s_hi = '0; seg_ok = 1'b0;
    case (seg_q)
      3'd1, 3'd2: begin
        s_fix  = (seg_q == 3'd1) ? cy - dd : cy + dd;
        seg_ok = (s_fix >= 0) && (s_fix < eff_h);
        s_lo   = (cx - dd < 0) ? SW'(0) : cx - dd;
        s_hi   = (cx + dd > eff_w - SW'(1)) ? eff_w - SW'(1) : cx + dd;
      end
      3'd3, 3'd4: begin
        s_fix  = (seg_q == 3'd3) ? cx - dd : cx + dd;
        seg_ok = (s_fix >= 0) && (s_fix < eff_w);
        s_lo   = (cy - dd + SW'(1) < 0) ? SW'(0) : cy - dd + SW'(1);
        s_hi   = (cy + dd - SW'(1) > eff_h - SW'(1)) ? eff_h - SW'(1) : cy + dd - SW'(1);
      end
      default: ;
    endcase
  end

  // current cell address
  logic signed [SW-1:0] cur_x, cur_y;
  logic [AW-1:0] addr;
  always_comb begin
    cur_x = seg_row_q ? pos_q : fix_q;
    cur_y = seg_row_q ? fix_q : pos_q;
    addr  = AW'(cur_y[YW-1:0]) * AW'(MAX_WIDTH) + AW'(cur_x[XW-1:0]);
  end

  // RAM port
  logic ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [ValW-1:0] ram_wdata, ram_rdata;

  lms_ram #(.Width(ValW), .Depth(Depth)) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  // request checks
  logic in_ok;
  logic op_bad;
  always_comb begin
    op_bad = 1'b0;
    unique case (op_e'(req_q.op))
      OP_POINT: op_bad = (cx >= eff_w) || (cy >= eff_h);
      OP_AREA:  op_bad = (SW'(req_q.left) >= eff_w) || (SW'(req_q.right) >= eff_w) ||
                         (SW'(req_q.top) >= eff_h) || (SW'(req_q.bottom) >= eff_h);
      default:  op_bad = (SW'(req_q.cell_x) >= eff_w) || (SW'(req_q.cell_y) >= eff_h);
    endcase
    in_ok = !op_bad;
  end

  logic [DivW-1:0] rem_sh;
  assign rem_sh = {rem_q[DivW-2:0], num_q[DivW-1]};

  // dividend intensity*(r-d); the quotient fits 16 bits, so the top byte is
  // already the remainder after the first eight steps
  logic [DivW-1:0] div_prod;
  assign div_prod = DivW'(req_q.intensity) * DivW'(req_q.radius - d_q);

  // segment / cell stepping decisions
  state_e seg_next_state, wr_next_state;
  logic area_row_done, area_all_done, last_seg_of_ring, last_ring;
  always_comb begin
    area_row_done    = (pos_q >= pos_end_q);
    area_all_done    = area_row_done && (fix_q >= SW'(req_q.bottom));
    last_seg_of_ring = (seg_q == 3'd4);
    last_ring        = (d_q >= req_q.radius);
    seg_next_state   = ST_CELL;
    if (op_e'(req_q.op) == OP_POINT && seg_q != 3'd0 && !(seg_ok && s_lo <= s_hi)) begin
      if (!last_seg_of_ring) seg_next_state = ST_SEG;
      else if (last_ring) seg_next_state = ST_RESP;
      else seg_next_state = ST_DIV;
    end
    if (op_e'(req_q.op) == OP_AREA &&
        (SW'(req_q.left) > SW'(req_q.right) || SW'(req_q.top) > SW'(req_q.bottom))) begin
      seg_next_state = ST_RESP;
    end
    wr_next_state = ST_CELL;
    unique case (op_e'(req_q.op))
      OP_POINT: begin
        if (pos_q >= hi_q) begin
          // the center cell is followed by the first ring, if the radius is nonzero
          if (!last_seg_of_ring && seg_q != 3'd0) wr_next_state = ST_SEG;
          else if (last_ring) wr_next_state = ST_RESP;
          else wr_next_state = ST_DIV;
        end
      end
      OP_AREA: if (area_all_done) wr_next_state = ST_RESP;
      default: wr_next_state = ST_RESP;
    endcase
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: if (clr_q == AW'(Depth - 1)) state_d = ST_IDLE;
      ST_IDLE:  if (in_valid_i) state_d = ST_NEXT;
      ST_NEXT: begin
        if (!in_ok) state_d = ST_RESP;
        else state_d = ST_SEG;
      end
      ST_DIV:   if (dcnt_q == 5'd0) state_d = ST_SEG;
      ST_SEG:   state_d = ST_CELL;
      ST_CELL:  state_d = ST_RD;
      ST_RD:    state_d = ST_WR;
      ST_WR:    state_d = ST_CELL;
      ST_RESP:  if (out_ready_i) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
    // data-path sequencing overrides below
    if (state_q == ST_SEG) state_d = seg_next_state;
    if (state_q == ST_WR)  state_d = wr_next_state;
  end

  // outputs and datapath control
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = addr;
    ram_wdata = sat_add(ram_rdata, amt_q);
    ram_raddr = addr;
    unique case (state_q)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_q;
        ram_wdata = '0;
      end
      ST_WR: begin
        ram_we = (op_e'(req_q.op) != OP_READ);
        if (op_e'(req_q.op) == OP_WRITE) begin
          ram_wdata = (req_q.write_value > LightOne) ? LightOne : req_q.write_value;
        end
      end
      default: ;
    endcase
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = (state_q == ST_RESP);
  assign out_data_o  = res_q;

  // datapath registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      clr_q   <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_CLEAR) clr_q <= clr_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) req_q <= in_data_i;
      end
      ST_NEXT: begin
        res_q.status     <= !in_ok;
        res_q.read_value <= '0;
        d_q              <= '0;
        seg_q            <= 3'd0;
        amt_q            <= req_q.intensity;
        unique case (op_e'(req_q.op))
          OP_POINT: ;
          OP_AREA: begin
            seg_row_q <= 1'b1;
            fix_q     <= SW'(req_q.top);
            pos_q     <= SW'(req_q.left);
            pos_end_q <= SW'(req_q.right);
          end
          default: begin
            seg_row_q <= 1'b1;
            fix_q     <= SW'(req_q.cell_y);
            pos_q     <= SW'(req_q.cell_x);
          end
        endcase
      end
      ST_DIV: begin
        // one quotient bit per cycle: intensity*(r-d)/r
        if (dcnt_q == 5'd17) begin
          dcnt_q <= 5'd16;
          num_q  <= {div_prod[ValW-1:0], {(DivW-ValW){1'b0}}};
          rem_q  <= {{ValW{1'b0}}, div_prod[DivW-1:ValW]};
        end else if (dcnt_q != 5'd0) begin
          num_q <= {num_q[DivW-2:0], (rem_sh >= DivW'(req_q.radius))};
          rem_q <= (rem_sh >= DivW'(req_q.radius)) ? rem_sh - DivW'(req_q.radius) : rem_sh;
          dcnt_q <= dcnt_q - 1'b1;
        end else begin
          amt_q <= num_q[ValW-1:0];
          seg_q <= 3'd1;
        end
      end
      ST_SEG: begin
        if (op_e'(req_q.op) == OP_POINT) begin
          if (seg_q == 3'd0) begin
            seg_row_q <= 1'b1;
            fix_q     <= cy;
            pos_q     <= cx;
            hi_q      <= cx;
          end else begin
            seg_row_q <= (seg_q == 3'd1) || (seg_q == 3'd2);
            fix_q     <= s_fix;
            pos_q     <= s_lo;
            hi_q      <= s_hi;
            if (!(seg_ok && s_lo <= s_hi)) begin
              if (!last_seg_of_ring) seg_q <= seg_q + 3'd1;
              else begin
                d_q    <= d_q + 8'd1;
                dcnt_q <= 5'd17;
              end
            end
          end
        end
      end
      ST_RD: ;
      ST_WR: begin
        if (op_e'(req_q.op) == OP_READ) res_q.read_value <= ram_rdata;
        unique case (op_e'(req_q.op))
          OP_POINT: begin
            if (pos_q >= hi_q) begin
              if (seg_q == 3'd0) begin
                d_q    <= 8'd1;
                dcnt_q <= 5'd17;
              end else if (!last_seg_of_ring) seg_q <= seg_q + 3'd1;
              else begin
                d_q    <= d_q + 8'd1;
                dcnt_q <= 5'd17;
              end
            end else pos_q <= pos_q + 1'b1;
          end
          OP_AREA: begin
            if (area_row_done) begin
              fix_q <= fix_q + 1'b1;
              pos_q <= SW'(req_q.left);
            end else pos_q <= pos_q + 1'b1;
          end
          default: ;
        endcase
      end
      default: ;
    endcase
  end

endmodule

// ===== rtl/lms_ram.sv =====
`timescale 1ns / 1ps
module lms_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 65536
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== tb/light_map_splat_saturating_top_tb.sv =====
`timescale 1ns / 1ps
module light_map_splat_saturating_top_tb;
  import lms_pkg::*;

  localparam int unsigned MapMax    = DefMaxWidth;
  localparam int unsigned CycleCap  = 20_000_000;
  localparam int unsigned RandItems = 580;

  // Shadow light map: predicts each op's status and read value
  class light_map_scoreboard;
    logic [ValW-1:0] cells [0:MapMax*MapMax-1];
    int unsigned cols;
    int unsigned rows;
    lms_out_t expected_q[$];
    int unsigned mismatches;

    function new();
      foreach (cells[i]) cells[i] = '0;
      cols = MapMax;
      rows = MapMax;
      mismatches = 0;
    endfunction

    // out-of-range sizes clamp to 1..MapMax
    function void set_size(cfg_idx_e idx, logic [CfgW-1:0] v);
      int unsigned e;
      e = (v == 0) ? 1 : ((v > MapMax) ? MapMax : v);
      if (idx == CFG_WIDTH) begin
        cols = e;
      end else begin
        rows = e;
      end
    endfunction

    function void add_light(int x, int y, int unsigned amt);
      int unsigned sum;
      sum = cells[y*MapMax + x] + amt;
      cells[y*MapMax + x] = (sum > LightOne) ? LightOne : sum[ValW-1:0];
    endfunction

    // ring d: full top/bottom rows, side columns without corners
    function bit splat_point(int cx, int cy, int rad, int unsigned inten);
      int d, k, row, col, lo, hi, p;
      int unsigned amt;
      if (cx >= cols || cy >= rows) return 0;
      add_light(cx, cy, inten);
      for (d = 1; d <= rad; d++) begin
        amt = inten * (rad - d) / rad;
        for (k = 0; k < 2; k++) begin
          row = (k == 0) ? cy - d : cy + d;
          if (row >= 0 && row < rows) begin
            lo = (cx - d < 0) ? 0 : cx - d;
            hi = (cx + d > cols - 1) ? cols - 1 : cx + d;
            for (p = lo; p <= hi; p++) add_light(p, row, amt);
          end
        end
        for (k = 0; k < 2; k++) begin
          col = (k == 0) ? cx - d : cx + d;
          if (col >= 0 && col < cols) begin
            lo = (cy - d + 1 < 0) ? 0 : cy - d + 1;
            hi = (cy + d - 1 > rows - 1) ? rows - 1 : cy + d - 1;
            for (p = lo; p <= hi; p++) add_light(col, p, amt);
          end
        end
      end
      return 1;
    endfunction

    function void note_input(lms_in_t it);
      lms_out_t res;
      int x, y;
      res = '0;
      case (op_e'(it.op))
        OP_POINT: res.status = !splat_point(it.center_x, it.center_y, it.radius, it.intensity);
        OP_AREA: begin
          if (it.left >= cols || it.right >= cols || it.top >= rows || it.bottom >= rows) begin
            res.status = 1'b1;
          end else begin
            for (y = it.top; y <= it.bottom; y++)
              for (x = it.left; x <= it.right; x++) add_light(x, y, it.intensity);
          end
        end
        default: begin
          if (it.cell_x >= cols || it.cell_y >= rows) begin
            res.status = 1'b1;
          end else if (op_e'(it.op) == OP_READ) begin
            res.read_value = cells[it.cell_y*MapMax + it.cell_x];
          end else begin
            cells[it.cell_y*MapMax + it.cell_x] =
              (it.write_value > LightOne) ? LightOne : it.write_value;
          end
        end
      endcase
      expected_q.push_back(res);
    endfunction

    function void check_result(lms_out_t got);
      lms_out_t exp_res;
      if (expected_q.size() == 0) begin
        $error("unexpected result transfer: read_value %0d status %0d",
               got.read_value, got.status);
        mismatches++;
        return;
      end
      exp_res = expected_q.pop_front();
      if (got.read_value !== exp_res.read_value) begin
        $error("read_value: expected %0d, actual %0d", exp_res.read_value, got.read_value);
        mismatches++;
      end
      if (got.status !== exp_res.status) begin
        $error("status: expected %0d, actual %0d", exp_res.status, got.status);
        mismatches++;
      end
    endfunction
  endclass

  logic             clk_i = 1'b0;
  logic             rst_ni;
  logic             in_valid_i;
  logic             in_ready_o;
  lms_in_t          in_data_i;
  logic             out_valid_o;
  logic             out_ready_i;
  lms_out_t         out_data_o;
  logic             cfg_valid_i;
  logic             cfg_ready_o;
  logic             cfg_index_i;
  logic [CfgW-1:0]  cfg_data_i;

  light_map_scoreboard sb = new();
  int unsigned cycles = 0;
  int unsigned send_idle = 0;
  int unsigned recv_idle = 0;

  light_map_splat_saturating_top uut (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .in_data_i,
    .out_valid_o, .out_ready_i, .out_data_o,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i
  );

  always #6 clk_i = ~clk_i;

  // cycle cap
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleCap) begin
      $display("FAILURE");
      $finish;
    end
  end

  // receiver stalls
  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= recv_idle);
  end

  // result monitor
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) sb.check_result(out_data_o);
  end

  task automatic send_item(lms_in_t it);
    int unsigned gap;
    gap = ($urandom_range(99) < send_idle) ? $urandom_range(1, 4) : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    sb.note_input(it);
  endtask

  task automatic drain();
    while (sb.expected_q.size() > 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [CfgW-1:0] v);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= v;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    sb.set_size(idx, v);
  endtask

  task automatic resize(logic [CfgW-1:0] w, logic [CfgW-1:0] h);
    in_valid_i <= 1'b0;
    drain();
    write_reg(CFG_WIDTH, w);
    write_reg(CFG_HEIGHT, h);
  endtask

  function automatic lms_in_t make_item(op_e op, int a, int b, int c, int d, int val);
    lms_in_t it;
    it = '0;
    it.op = op;
    case (op)
      OP_POINT: begin
        it.center_x = CoordW'(a); it.center_y = CoordW'(b); it.radius = CoordW'(c);
        it.intensity = ValW'(val);
      end
      OP_AREA: begin
        it.left = CoordW'(a); it.top = CoordW'(b); it.right = CoordW'(c);
        it.bottom = CoordW'(d); it.intensity = ValW'(val);
      end
      OP_READ:  begin it.cell_x = CoordW'(a); it.cell_y = CoordW'(b); end
      default:  begin
        it.cell_x = CoordW'(a); it.cell_y = CoordW'(b); it.write_value = ValW'(val);
      end
    endcase
    return it;
  endfunction

  // mostly inside the map, sometimes anywhere in the field range
  function automatic int pick(int unsigned n);
    return ($urandom_range(9) == 0) ? $urandom_range(0, 255) : $urandom_range(0, n - 1);
  endfunction

  // keeps lights small on big maps so the run stays short
  function automatic lms_in_t rand_item();
    lms_in_t it;
    int unsigned span;
    span = (sb.cols * sb.rows > 1024) ? 12 : 255;
    it.op          = 2'($urandom_range(0, 3));
    it.center_x    = CoordW'(pick(sb.cols));
    it.center_y    = CoordW'(pick(sb.rows));
    it.radius      = CoordW'(($urandom_range(19) == 0 && span == 255) ? $urandom_range(0, 255)
                   : $urandom_range(0, (span == 255) ? 18 : span));
    it.intensity   = ValW'(($urandom_range(3) == 0) ? $urandom_range(0, 65535)
                   : $urandom_range(0, 3000));
    it.left        = CoordW'(pick(sb.cols));
    it.top         = CoordW'(pick(sb.rows));
    it.right       = CoordW'(($urandom_range(7) == 0) ? pick(sb.cols)
                   : ((it.left + $urandom_range(0, span) > sb.cols - 1) ? sb.cols - 1
                      : it.left + $urandom_range(0, span)));
    it.bottom      = CoordW'(($urandom_range(7) == 0) ? pick(sb.rows)
                   : ((it.top + $urandom_range(0, span) > sb.rows - 1) ? sb.rows - 1
                      : it.top + $urandom_range(0, span)));
    it.cell_x      = CoordW'(pick(sb.cols));
    it.cell_y      = CoordW'(pick(sb.rows));
    it.write_value = ValW'(($urandom_range(3) == 0) ? $urandom_range(0, 65535)
                   : $urandom_range(0, 32768));
    return it;
  endfunction

  int unsigned phase_w [7] = '{16, 256, 1, 0, 300, 37, 5};
  int unsigned phase_h [7] = '{12, 256, 1, 0, 511, 5, 200};

  initial begin
    int unsigned sent;
    rst_ni      <= 1'b0;
    in_valid_i  <= 1'b0;
    in_data_i   <= '0;
    cfg_valid_i <= 1'b0;
    cfg_index_i <= CFG_WIDTH;
    cfg_data_i  <= '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: full-size map after reset
    send_item(make_item(OP_READ, 0, 0, 0, 0, 0));
    send_item(make_item(OP_WRITE, 255, 255, 0, 0, 65535));
    send_item(make_item(OP_READ, 255, 255, 0, 0, 0));
    send_item(make_item(OP_AREA, 0, 0, 255, 0, 65535));
    send_item(make_item(OP_AREA, 5, 0, 3, 2, 100));
    send_item(make_item(OP_POINT, 0, 0, 3, 0, 32768));
    send_item(make_item(OP_POINT, 255, 255, 0, 0, 0));
    send_item(make_item(OP_POINT, 128, 128, 8, 0, 0));
    send_item(make_item(OP_POINT, 128, 128, 8, 0, 65535));
    send_item(make_item(OP_READ, 128, 129, 0, 0, 0));
    send_item(make_item(OP_READ, 1, 1, 0, 0, 0));

    // directed: small map, rejects and clipping
    resize(16, 12);
    send_item(make_item(OP_POINT, 20, 3, 2, 0, 500));
    send_item(make_item(OP_POINT, 3, 12, 2, 0, 500));
    send_item(make_item(OP_AREA, 0, 0, 16, 4, 500));
    send_item(make_item(OP_AREA, 0, 0, 4, 12, 500));
    send_item(make_item(OP_AREA, 2, 9, 4, 3, 500));
    send_item(make_item(OP_READ, 16, 0, 0, 0, 0));
    send_item(make_item(OP_WRITE, 0, 12, 0, 0, 700));
    send_item(make_item(OP_POINT, 8, 6, 255, 0, 40000));
    send_item(make_item(OP_AREA, 0, 0, 15, 11, 1));
    send_item(make_item(OP_READ, 15, 11, 0, 0, 0));
    send_item(make_item(OP_WRITE, 15, 11, 0, 0, 0));
    send_item(make_item(OP_READ, 15, 11, 0, 0, 0));

    // random phases over several map sizes
    sent = 0;
    for (int ph = 0; ph < 7; ph++) begin
      resize(CfgW'(phase_w[ph]), CfgW'(phase_h[ph]));
      for (int n = 0; n < RandItems / 7 + 1; n++) begin
        if (sent < RandItems / 3) begin
          send_idle = 36; recv_idle = 48;
        end else if (sent < 2 * RandItems / 3) begin
          send_idle = 48; recv_idle = 36;
        end else begin
          send_idle = 0; recv_idle = 0;
        end
        send_item(rand_item());
        sent++;
      end
    end

    in_valid_i <= 1'b0;
    drain();
    repeat (20) @(posedge clk_i);
    if (sb.expected_q.size() > 0) begin
      $error("%0d expected results never arrived", sb.expected_q.size());
      sb.mismatches++;
    end
    if (sb.mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
